FILE: hdl/hlsrgb_pkg.sv
// ----------------------------------------------------------------------------
// HLS to RGB colour unit: shared package
// Field widths, register indexes, hue constants and the hue classifier used
// by the front and back parts of the colour unit.
// ----------------------------------------------------------------------------
package hlsrgb_pkg;

  // Fixed field widths of the input item, the reduced hue and the ramp position.
  localparam int HUE_REQ_W  = 11;
  localparam int RAND_HUE_W = 9;
  localparam int HUE_W      = 9;
  localparam int HUE_T_W    = 6;

  // Configuration port geometry and register indexes.
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int NUM_REGS   = 6;
  localparam int REG_IDX_W  = 3;

  typedef logic [REG_IDX_W-1:0] reg_index_t;

  localparam reg_index_t REG_LIGHT_MIN = 3'd0;
  localparam reg_index_t REG_LIGHT_MAX = 3'd1;
  localparam reg_index_t REG_SAT_MIN   = 3'd2;
  localparam reg_index_t REG_SAT_MAX   = 3'd3;
  localparam reg_index_t REG_ALPHA_MIN = 3'd4;
  localparam reg_index_t REG_ALPHA_MAX = 3'd5;

  // Hue geometry in degrees.
  localparam int HUE_FULL      = 360;
  localparam int HUE_SEXTANT   = 60;
  localparam int HUE_HIGH_END  = 180;
  localparam int HUE_FALL_END  = 240;
  localparam int HUE_OFS_RED   = 120;
  localparam int HUE_OFS_GREEN = 0;
  localparam int HUE_OFS_BLUE  = 240;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  // Segment of the piecewise hue ramp.
  typedef logic [1:0] ramp_kind_t;

  localparam ramp_kind_t KIND_RAMP = 2'd0;
  localparam ramp_kind_t KIND_HIGH = 2'd1;
  localparam ramp_kind_t KIND_LOW  = 2'd2;

  // Ramp segment of one channel and its position along a sloped segment.
  typedef struct packed {
    ramp_kind_t           kind;
    logic [HUE_T_W-1:0]   t;
  } hue_class_t;

  // Classifies the hue of one channel, offset from the base hue.
  function automatic hue_class_t hue_classify(input logic [HUE_W-1:0] hue,
                                              input logic [HUE_W-1:0] offset);
    logic [HUE_W:0] sum;
    logic [HUE_W:0] hc;
    hue_class_t     c;
    sum = {1'b0, hue} + {1'b0, offset};
    hc  = (sum >= (HUE_W+1)'(HUE_FULL)) ? sum - (HUE_W+1)'(HUE_FULL) : sum;
    if (hc < (HUE_W+1)'(HUE_SEXTANT)) begin
      c.kind = KIND_RAMP;
      c.t    = hc[HUE_T_W-1:0];
    end else if (hc < (HUE_W+1)'(HUE_HIGH_END)) begin
      c.kind = KIND_HIGH;
      c.t    = '0;
    end else if (hc < (HUE_W+1)'(HUE_FALL_END)) begin
      c.kind = KIND_RAMP;
      c.t    = HUE_T_W'((HUE_W+1)'(HUE_FALL_END) - hc);
    end else begin
      c.kind = KIND_LOW;
      c.t    = '0;
    end
    return c;
  endfunction

endpackage

FILE: hdl/random_hls_to_rgb_color_unit.sv
// ----------------------------------------------------------------------------
// Random HLS to RGB colour unit: top level
// Turns a hue request and three random fractions into an RGBA colour in
// unsigned fixed point with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// The unit accepts one item per clock cycle and delivers one colour per item,
// in order, sustaining one item per cycle while the output is taken. From its
// input transfer an item passes through the front stage register (hue
// reduction, ramp classification and the three interpolation multipliers),
// the queue, and the back datapath registers after the p2 multiplier, the ramp
// multipliers and the reciprocal-of-sixty multipliers, then the output
// register, which takes the corrected channel values. The four-entry
// queue lets the front keep accepting while the back is held by a stalled
// output. Configuration writes are meant for when the unit is idle.
module random_hls_to_rgb_color_unit
  import hlsrgb_pkg::*;
#(
  parameter  int FRAC_BITS = 12,
  localparam int IN_BITS   = HUE_REQ_W + RAND_HUE_W + 3 * FRAC_BITS,
  localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS  = 4 * (FRAC_BITS + 1),
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  // Input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // Fields from bit 0: hue_request, random_hue, rand_light, rand_sat, rand_alpha
  input  logic [IN_W-1:0]       in_tdata,
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // Fields from bit 0: red, green, blue, alpha
  output logic [OUT_W-1:0]      out_tdata
);

  localparam int F       = FRAC_BITS;
  localparam int RL_LO   = HUE_REQ_W + RAND_HUE_W;
  localparam int RS_LO   = RL_LO + F;
  localparam int RA_LO   = RS_LO + F;
  localparam int ENTRY_W = 3 * $bits(hue_class_t) + 3 * (F + 1);

  logic [NUM_REGS-1:0][F:0]  bounds;
  logic signed [HUE_REQ_W-1:0] hue_request;
  logic [RAND_HUE_W-1:0]     random_hue;
  logic [F-1:0]              rand_light;
  logic [F-1:0]              rand_sat;
  logic [F-1:0]              rand_alpha;

  logic                      push;
  logic                      queue_full;
  logic                      pop;
  logic                      queue_empty;
  hue_class_t [2:0]          f_cls;
  logic [F:0]                f_light;
  logic [F:0]                f_sat;
  logic [F:0]                f_alpha;
  logic [ENTRY_W-1:0]        q_wdata;
  logic [ENTRY_W-1:0]        q_rdata;
  hue_class_t [2:0]          b_cls;
  logic [F:0]                b_light;
  logic [F:0]                b_sat;
  logic [F:0]                b_alpha;

  logic [F:0]                red;
  logic [F:0]                green;
  logic [F:0]                blue;
  logic [F:0]                alpha;

  // Unpack the input transfer.
  assign hue_request = in_tdata[HUE_REQ_W-1:0];
  assign random_hue  = in_tdata[RL_LO-1:HUE_REQ_W];
  assign rand_light  = in_tdata[RS_LO-1:RL_LO];
  assign rand_sat    = in_tdata[RA_LO-1:RS_LO];
  assign rand_alpha  = in_tdata[RA_LO+F-1:RA_LO];

  // Configuration registers.
  hlsrgb_cfg #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .bounds  (bounds)
  );

  // Front part: accept and classify.
  hlsrgb_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .hue_request (hue_request),
    .random_hue  (random_hue),
    .rand_light  (rand_light),
    .rand_sat    (rand_sat),
    .rand_alpha  (rand_alpha),
    .bounds      (bounds),
    .push        (push),
    .queue_full  (queue_full),
    .cls         (f_cls),
    .light       (f_light),
    .sat         (f_sat),
    .alpha       (f_alpha)
  );

  // Queue between the two parts.
  assign q_wdata = {f_alpha, f_sat, f_light, f_cls};
  assign {b_alpha, b_sat, b_light, b_cls} = q_rdata;

  hlsrgb_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (q_wdata),
    .full  (queue_full),
    .pop   (pop),
    .rdata (q_rdata),
    .empty (queue_empty)
  );

  // Back part: colour conversion and output register.
  hlsrgb_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .queue_empty (queue_empty),
    .pop         (pop),
    .cls         (b_cls),
    .light       (b_light),
    .sat         (b_sat),
    .alpha       (b_alpha),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .alpha_out   (alpha)
  );

  // Pack the result transfer, zero-filled to whole bytes.
  assign out_tdata = OUT_W'({alpha, blue, green, red});

endmodule

FILE: hdl/hlsrgb_cfg.sv
// ----------------------------------------------------------------------------
// HLS to RGB colour unit: configuration registers
// APB-style register file holding the interpolation bounds; presents each
// bound limited to one.
// ----------------------------------------------------------------------------
module hlsrgb_cfg
  import hlsrgb_pkg::*;
#(
  parameter int FRAC_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [CFG_ADDR_W-1:0]               paddr,
  input  logic [CFG_DATA_W-1:0]               pwdata,
  output logic [CFG_DATA_W-1:0]               prdata,
  output logic                                pready,
  output logic [NUM_REGS-1:0][FRAC_BITS:0]    bounds
);

  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  logic [NUM_REGS-1:0][FRAC_BITS:0] regs_r;
  reg_index_t                       idx;
  logic                             wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes; writes beyond the last register are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r[REG_LIGHT_MIN] <= '0;
      regs_r[REG_LIGHT_MAX] <= ONE;
      regs_r[REG_SAT_MIN]   <= '0;
      regs_r[REG_SAT_MAX]   <= ONE;
      regs_r[REG_ALPHA_MIN] <= ONE;
      regs_r[REG_ALPHA_MAX] <= ONE;
    end else if (wr_en && (idx < reg_index_t'(NUM_REGS))) begin
      regs_r[idx] <= pwdata[FRAC_BITS:0];
    end
  end

  // Read back the stored value.
  always_comb begin
    if (idx < reg_index_t'(NUM_REGS)) begin
      prdata = CFG_DATA_W'(regs_r[idx]);
    end else begin
      prdata = '0;
    end
  end

  // A bound above one is read as one.
  always_comb begin
    for (int i = 0; i < NUM_REGS; i++) begin
      bounds[i] = (regs_r[i] > ONE) ? ONE : regs_r[i];
    end
  end

endmodule

FILE: hdl/hlsrgb_front.sv
// ----------------------------------------------------------------------------
// HLS to RGB colour unit: front part
// Accepts an item, reduces the hue, classifies each channel's ramp segment
// and interpolates lightness, saturation and opacity, in one register stage.
// ----------------------------------------------------------------------------
module hlsrgb_front
  import hlsrgb_pkg::*;
#(
  parameter int FRAC_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [HUE_REQ_W-1:0]       hue_request,
  input  logic [RAND_HUE_W-1:0]             random_hue,
  input  logic [FRAC_BITS-1:0]              rand_light,
  input  logic [FRAC_BITS-1:0]              rand_sat,
  input  logic [FRAC_BITS-1:0]              rand_alpha,
  input  logic [NUM_REGS-1:0][FRAC_BITS:0]  bounds,
  output logic                              push,
  input  logic                              queue_full,
  output hue_class_t [2:0]                  cls,
  output logic [FRAC_BITS:0]                light,
  output logic [FRAC_BITS:0]                sat,
  output logic [FRAC_BITS:0]                alpha
);

  localparam int RAW_W = HUE_REQ_W - 1;

  // Interpolates between two bounds by a fraction, truncating the step.
  function automatic logic [FRAC_BITS:0] lerp(input logic [FRAC_BITS:0]   lo,
                                              input logic [FRAC_BITS:0]   hi,
                                              input logic [FRAC_BITS-1:0] r);
    logic [FRAC_BITS:0]   diff;
    logic [2*FRAC_BITS:0] prod;
    logic [FRAC_BITS:0]   step;
    diff = (hi >= lo) ? hi - lo : lo - hi;
    prod = (2*FRAC_BITS+1)'(r) * (2*FRAC_BITS+1)'(diff);
    step = prod[2*FRAC_BITS:FRAC_BITS];
    return (hi >= lo) ? lo + step : lo - step;
  endfunction

  logic                    valid_r;
  logic                    advance;
  logic [RAW_W-1:0]        hue_raw;
  logic [RAW_W-1:0]        hue_mod;
  logic [HUE_W-1:0]        hue;
  hue_class_t [2:0]        cls_nxt;
  hue_class_t [2:0]        cls_r;
  logic [FRAC_BITS:0]      light_r;
  logic [FRAC_BITS:0]      sat_r;
  logic [FRAC_BITS:0]      alpha_r;

  // The stage moves on when empty or when its item enters the queue.
  assign advance  = !valid_r || !queue_full;
  assign in_ready = advance;
  assign push     = valid_r && !queue_full;

  // Hue selection and reduction modulo a full turn.
  always_comb begin
    hue_raw = hue_request[HUE_REQ_W-1] ? RAW_W'(random_hue) : hue_request[RAW_W-1:0];
    if (hue_raw >= RAW_W'(2 * HUE_FULL)) begin
      hue_mod = hue_raw - RAW_W'(2 * HUE_FULL);
    end else if (hue_raw >= RAW_W'(HUE_FULL)) begin
      hue_mod = hue_raw - RAW_W'(HUE_FULL);
    end else begin
      hue_mod = hue_raw;
    end
    hue        = hue_mod[HUE_W-1:0];
    cls_nxt[0] = hue_classify(hue, HUE_W'(HUE_OFS_RED));
    cls_nxt[1] = hue_classify(hue, HUE_W'(HUE_OFS_GREEN));
    cls_nxt[2] = hue_classify(hue, HUE_W'(HUE_OFS_BLUE));
  end

  // Stage valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= in_valid;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      cls_r   <= cls_nxt;
      light_r <= lerp(bounds[REG_LIGHT_MIN], bounds[REG_LIGHT_MAX], rand_light);
      sat_r   <= lerp(bounds[REG_SAT_MIN], bounds[REG_SAT_MAX], rand_sat);
      alpha_r <= lerp(bounds[REG_ALPHA_MIN], bounds[REG_ALPHA_MAX], rand_alpha);
    end
  end

  assign cls   = cls_r;
  assign light = light_r;
  assign sat   = sat_r;
  assign alpha = alpha_r;

endmodule

FILE: hdl/hlsrgb_queue.sv
// ----------------------------------------------------------------------------
// HLS to RGB colour unit: decoupling queue
// Short first-in first-out queue between the front and the back parts.
// ----------------------------------------------------------------------------
module hlsrgb_queue
  import hlsrgb_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  logic [QUEUE_DEPTH-1:0][WIDTH-1:0] slots_r;
  logic [PTR_W-1:0]                  wr_ptr_r;
  logic [PTR_W-1:0]                  rd_ptr_r;
  logic [CNT_W-1:0]                  count_r;
  logic                              do_push;
  logic                              do_pop;

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: hdl/hlsrgb_back.sv
// ----------------------------------------------------------------------------
// HLS to RGB colour unit: back part
// Three-stage datapath from lightness and saturation to the p1/p2 ramp
// levels and the three colour channels, followed by the output register.
// ----------------------------------------------------------------------------
module hlsrgb_back
  import hlsrgb_pkg::*;
#(
  parameter int FRAC_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 queue_empty,
  output logic                 pop,
  input  hue_class_t [2:0]     cls,
  input  logic [FRAC_BITS:0]   light,
  input  logic [FRAC_BITS:0]   sat,
  input  logic [FRAC_BITS:0]   alpha,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [FRAC_BITS:0]   red,
  output logic [FRAC_BITS:0]   green,
  output logic [FRAC_BITS:0]   blue,
  output logic [FRAC_BITS:0]   alpha_out
);

  localparam int             F     = FRAC_BITS;
  localparam logic [F:0]     ONE   = (F+1)'(1) << F;
  localparam logic [F:0]     HALF  = ONE >> 1;
  // Ramp product width and reciprocal of sixty scaled by 2^XW.
  localparam int             XW    = F + 1 + HUE_T_W;
  localparam int             MW    = XW - 5;
  localparam logic [MW-1:0]  RECIP = MW'((64'd1 << XW) / HUE_SEXTANT);

  // Channel value from its segment; the quotient estimate is corrected once.
  function automatic logic [F:0] chan_value(input ramp_kind_t    kind,
                                            input logic [F:0]    p1,
                                            input logic [F:0]    p2,
                                            input logic [XW-1:0] x,
                                            input logic [MW-1:0] q0);
    logic [XW:0]   prod60;
    logic [XW:0]   rem;
    logic [MW-1:0] q;
    logic [F:0]    v;
    prod60 = (XW+1)'(q0) * (XW+1)'(HUE_SEXTANT);
    rem    = (XW+1)'(x) - prod60;
    q      = (rem >= (XW+1)'(HUE_SEXTANT)) ? q0 + 1'b1 : q0;
    case (kind)
      KIND_RAMP: v = p1 + q[F:0];
      KIND_HIGH: v = p2;
      KIND_LOW:  v = p1;
      default:   v = p1;
    endcase
    return v;
  endfunction

  logic                     advance;

  // Stage one: p1 and p2.
  logic                     b1_valid_r;
  logic [F+1:0]             mul_op;
  logic [2*F+2:0]           mul_prod;
  logic [F+2:0]             mul_sh;
  logic [F+2:0]             p2_wide;
  logic [F:0]               p2_nxt;
  logic [F+1:0]             twice_l;
  logic [F+1:0]             p1_wide;
  logic [F:0]               b1_p1_r;
  logic [F:0]               b1_p2_r;
  hue_class_t [2:0]         b1_cls_r;
  logic                     b1_grey_r;
  logic [F:0]               b1_light_r;
  logic [F:0]               b1_alpha_r;

  // Stage two: ramp products.
  logic                     b2_valid_r;
  logic [F:0]               span;
  logic [2:0][XW-1:0]       b2_x_r;
  logic [F:0]               b2_p1_r;
  logic [F:0]               b2_p2_r;
  ramp_kind_t [2:0]         b2_kind_r;
  logic                     b2_grey_r;
  logic [F:0]               b2_light_r;
  logic [F:0]               b2_alpha_r;

  // Stage three: quotient estimates.
  logic                     b3_valid_r;
  logic [2:0][XW+MW-1:0]    recip_prod;
  logic [2:0][MW-1:0]       b3_q0_r;
  logic [2:0][XW-1:0]       b3_x_r;
  logic [F:0]               b3_p1_r;
  logic [F:0]               b3_p2_r;
  ramp_kind_t [2:0]         b3_kind_r;
  logic                     b3_grey_r;
  logic [F:0]               b3_light_r;
  logic [F:0]               b3_alpha_r;

  // Output register.
  logic                     out_valid_r;
  logic [2:0][F:0]          chan;
  logic [F:0]               red_r;
  logic [F:0]               green_r;
  logic [F:0]               blue_r;
  logic [F:0]               alpha_r;

  // The whole datapath holds while a result waits at the output.
  assign advance = !out_valid_r || out_ready;
  assign pop     = advance && !queue_empty;

  // p2 from lightness and saturation, then p1 = 2L - p2.
  always_comb begin
    mul_op   = (light <= HALF) ? (F+2)'(sat) + (F+2)'(ONE) : (F+2)'(sat);
    mul_prod = (2*F+3)'(light) * (2*F+3)'(mul_op);
    mul_sh   = mul_prod[2*F+2:F];
    if (light <= HALF) begin
      p2_wide = mul_sh;
    end else begin
      p2_wide = (F+3)'(light) + (F+3)'(sat) - mul_sh;
    end
    if (p2_wide > (F+3)'(ONE)) begin
      p2_wide = (F+3)'(ONE);
    end
    if (p2_wide < (F+3)'(light)) begin
      p2_wide = (F+3)'(light);
    end
    p2_nxt  = p2_wide[F:0];
    twice_l = {light, 1'b0};
    p1_wide = (twice_l >= (F+2)'(p2_nxt)) ? twice_l - (F+2)'(p2_nxt) : '0;
  end

  // Ramp span, reciprocal-of-sixty estimates of the ramp products, and channel values.
  always_comb begin
    span = b1_p2_r - b1_p1_r;
    for (int c = 0; c < 3; c++) begin
      recip_prod[c] = (XW+MW)'(b2_x_r[c]) * (XW+MW)'(RECIP);
      chan[c]       = b3_grey_r ? b3_light_r
                                : chan_value(b3_kind_r[c], b3_p1_r, b3_p2_r,
                                             b3_x_r[c], b3_q0_r[c]);
    end
  end

  // Valid flags of the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r  <= 1'b0;
      b2_valid_r  <= 1'b0;
      b3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      b1_valid_r  <= pop;
      b2_valid_r  <= b1_valid_r;
      b3_valid_r  <= b2_valid_r;
      out_valid_r <= b3_valid_r;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (advance) begin
      b1_p1_r    <= p1_wide[F:0];
      b1_p2_r    <= p2_nxt;
      b1_cls_r   <= cls;
      b1_grey_r  <= (sat == '0);
      b1_light_r <= light;
      b1_alpha_r <= alpha;

      for (int c = 0; c < 3; c++) begin
        b2_x_r[c]    <= XW'(span) * XW'(b1_cls_r[c].t);
        b2_kind_r[c] <= b1_cls_r[c].kind;
      end
      b2_p1_r    <= b1_p1_r;
      b2_p2_r    <= b1_p2_r;
      b2_grey_r  <= b1_grey_r;
      b2_light_r <= b1_light_r;
      b2_alpha_r <= b1_alpha_r;

      for (int c = 0; c < 3; c++) begin
        b3_q0_r[c] <= recip_prod[c][XW+MW-1:XW];
      end
      b3_x_r     <= b2_x_r;
      b3_kind_r  <= b2_kind_r;
      b3_p1_r    <= b2_p1_r;
      b3_p2_r    <= b2_p2_r;
      b3_grey_r  <= b2_grey_r;
      b3_light_r <= b2_light_r;
      b3_alpha_r <= b2_alpha_r;

      red_r   <= chan[0];
      green_r <= chan[1];
      blue_r  <= chan[2];
      alpha_r <= b3_alpha_r;
    end
  end

  assign out_valid = out_valid_r;
  assign red       = red_r;
  assign green     = green_r;
  assign blue      = blue_r;
  assign alpha_out = alpha_r;

endmodule

FILE: tb/sv/tb_random_hls_to_rgb_color_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the random HLS to RGB colour unit
// Drives hue requests and random fractions into the unit under several
// register settings and checks every colour against a cycle-free predictor
// of the fixed-point HLS conversion. The sender runs in bursts, the receiver
// stalls on its own pattern, and one long receiver hold fills the unit.
// ----------------------------------------------------------------------------
module tb_random_hls_to_rgb_color_unit;
  import hlsrgb_pkg::*;

  localparam int FRAC_BITS  = 12;
  localparam int IN_BITS    = HUE_REQ_W + RAND_HUE_W + 3 * FRAC_BITS;
  localparam int IN_W       = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = 4 * (FRAC_BITS + 1);
  localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8;
  localparam int CLK_HALF   = 4;
  localparam int CYCLE_CAP  = 300000;
  localparam int PHASES     = 5;
  localparam int PHASE_ITEMS = 225;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT = 20;
  localparam int REPORT_MAX = 10;
  localparam longint unsigned UNIT = longint'(1) << FRAC_BITS;

  // One colour request, packed exactly as it travels on in_tdata.
  typedef struct packed {
    logic [FRAC_BITS-1:0]  alpha;
    logic [FRAC_BITS-1:0]  sat;
    logic [FRAC_BITS-1:0]  light;
    logic [RAND_HUE_W-1:0] rnd_hue;
    logic [HUE_REQ_W-1:0]  hue_req;
  } colour_req_t;

  // One colour, packed exactly as it travels on out_tdata.
  typedef struct packed {
    logic [OUT_W-OUT_BITS-1:0] pad;
    logic [FRAC_BITS:0]        alpha;
    logic [FRAC_BITS:0]        blue;
    logic [FRAC_BITS:0]        green;
    logic [FRAC_BITS:0]        red;
  } rgba_t;

  // Directed row: hue request, random hue, light, sat, alpha fractions, then
  // whether the colour is typed in, and the typed red, green, blue, alpha.
  typedef struct {
    int hreq;
    int rhue;
    int rl;
    int rs;
    int ra;
    bit fixed;
    int er;
    int eg;
    int eb;
    int ea;
  } dir_row_t;

  localparam int DIR_ROWS = 23;

  // Rows are run under the register values after reset, where lightness and
  // saturation equal their fractions and opacity is always one.
  dir_row_t dir_rows [DIR_ROWS] = '{
    // Zero saturation gives grey at the lightness
    '{0,     0,    0,    0,    0, 1'b1,    0,    0,    0, 4096},
    '{0,     0, 2048,    0, 4095, 1'b1, 2048, 2048, 2048, 4096},
    '{1023, 511, 4095,   0,    0, 1'b1, 4095, 4095, 4095, 4096},
    // Hue boundaries of the ramps
    '{0,     0, 2048, 4095,    0, 1'b0, 0, 0, 0, 0},
    '{59,    0, 1024, 3000,  100, 1'b0, 0, 0, 0, 0},
    '{60,    0, 3000, 1000,  200, 1'b0, 0, 0, 0, 0},
    '{119,   0, 2049, 4095,  300, 1'b0, 0, 0, 0, 0},
    '{120,   0, 2047, 4095,  400, 1'b0, 0, 0, 0, 0},
    '{179,   0,  700, 2500,  500, 1'b0, 0, 0, 0, 0},
    '{180,   0, 3500,  600,  600, 1'b0, 0, 0, 0, 0},
    '{239,   0, 1500, 4095,  700, 1'b0, 0, 0, 0, 0},
    '{240,   0, 2600, 3100,  800, 1'b0, 0, 0, 0, 0},
    '{299,   0,  333, 1111,  900, 1'b0, 0, 0, 0, 0},
    '{300,   0, 3777, 2222, 1000, 1'b0, 0, 0, 0, 0},
    '{359,   0, 2048, 2048, 1100, 1'b0, 0, 0, 0, 0},
    // Requests at or above a full turn wrap round
    '{360,   0, 4095, 4095, 1200, 1'b0, 0, 0, 0, 0},
    '{719,   0, 1800, 3900, 1300, 1'b0, 0, 0, 0, 0},
    '{1023,  0, 2900, 1700, 1400, 1'b0, 0, 0, 0, 0},
    // Negative requests take the random hue, which also wraps
    '{-1,    0, 2048, 4095, 1500, 1'b0, 0, 0, 0, 0},
    '{-1,  359, 1234, 3456, 1600, 1'b0, 0, 0, 0, 0},
    '{-1,  360, 3210, 2345, 1700, 1'b0, 0, 0, 0, 0},
    '{-1024, 511, 2500, 4000, 1800, 1'b0, 0, 0, 0, 0},
    '{-677, 180,    1,    1,    1, 1'b0, 0, 0, 0, 0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_W-1:0]      out_tdata;

  // Predictor's copy of the bound registers.
  logic [FRAC_BITS:0] bound_regs [NUM_REGS];
  rgba_t              colour_queue [$];
  int                 fault_count = 0;
  int                 cycle_count = 0;
  int                 burst_left;
  bit                 hold_req;

  random_hls_to_rgb_color_unit #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Clock.
  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  // Cycle limit in case the unit hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_CAP) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Register value as the datapath reads it: anything above one is one.
  function automatic longint unsigned bound_value(input int idx);
    longint unsigned v;
    v = bound_regs[idx];
    return (v > UNIT) ? UNIT : v;
  endfunction

  // Interpolation between two bounds; a reversed pair truncates towards lo.
  function automatic longint unsigned bound_mix(input longint unsigned lo,
                                                input longint unsigned hi,
                                                input longint unsigned r);
    if (hi >= lo)
      return lo + ((r * (hi - lo)) >> FRAC_BITS);
    return lo - ((r * (lo - hi)) >> FRAC_BITS);
  endfunction

  // Piecewise hue ramp between the two HLS levels.
  function automatic longint unsigned hue_ramp(input longint unsigned q1,
                                               input longint unsigned q2,
                                               input longint unsigned hue);
    longint unsigned h;
    h = hue % HUE_FULL;
    if (h < HUE_SEXTANT)
      return q1 + ((q2 - q1) * h) / HUE_SEXTANT;
    if (h < HUE_HIGH_END)
      return q2;
    if (h < HUE_FALL_END)
      return q1 + ((q2 - q1) * (HUE_FALL_END - h)) / HUE_SEXTANT;
    return q1;
  endfunction

  // Expected colour of one request under the current register values.
  function automatic rgba_t hls_colour(input colour_req_t req);
    longint unsigned h, l, s, a, p1, p2;
    rgba_t           c;
    if (req.hue_req[HUE_REQ_W-1])
      h = longint'(req.rnd_hue) % HUE_FULL;
    else
      h = longint'(req.hue_req) % HUE_FULL;
    l = bound_mix(bound_value(REG_LIGHT_MIN), bound_value(REG_LIGHT_MAX), req.light);
    s = bound_mix(bound_value(REG_SAT_MIN), bound_value(REG_SAT_MAX), req.sat);
    a = bound_mix(bound_value(REG_ALPHA_MIN), bound_value(REG_ALPHA_MAX), req.alpha);
    if (l <= UNIT / 2)
      p2 = (l * (s + UNIT)) >> FRAC_BITS;
    else
      p2 = l + s - ((l * s) >> FRAC_BITS);
    if (p2 > UNIT)
      p2 = UNIT;
    if (p2 < l)
      p2 = l;
    p1 = (2 * l >= p2) ? 2 * l - p2 : 0;
    c = '0;
    if (s == 0) begin
      c.red   = l[FRAC_BITS:0];
      c.green = l[FRAC_BITS:0];
      c.blue  = l[FRAC_BITS:0];
    end else begin
      c.red   = (FRAC_BITS+1)'(hue_ramp(p1, p2, h + HUE_OFS_RED));
      c.green = (FRAC_BITS+1)'(hue_ramp(p1, p2, h + HUE_OFS_GREEN));
      c.blue  = (FRAC_BITS+1)'(hue_ramp(p1, p2, h + HUE_OFS_BLUE));
    end
    c.alpha = a[FRAC_BITS:0];
    return c;
  endfunction

  // Register write over the configuration port; unknown indexes are dropped.
  task automatic cfg_write(input int idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = CFG_ADDR_W'(idx * 4);
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx < NUM_REGS)
      bound_regs[idx] = value[FRAC_BITS:0];
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // Sender gap with junk on the data bus; n sets its length.
  task automatic idle_gap(input int n);
    @(negedge clk);
    in_tvalid = 1'b0;
    in_tdata  = IN_W'({$urandom, $urandom});
    repeat (n - 1) @(negedge clk);
  endtask

  // Offers one request and records the expected colour on its transfer.
  task automatic send_request(input colour_req_t req, input bit fixed,
                              input rgba_t typed);
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = req;
    do @(posedge clk); while (!in_tready);
    colour_queue.push_back(fixed ? typed : hls_colour(req));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      if ($urandom_range(0, 3) != 0)
        idle_gap($urandom_range(1, 8));
    end
  endtask

  // Fraction biased towards its extremes and the midpoint.
  function automatic logic [FRAC_BITS-1:0] random_fraction();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return FRAC_BITS'(UNIT / 2);
      default: return FRAC_BITS'($urandom);
    endcase
  endfunction

  function automatic colour_req_t random_request();
    colour_req_t req;
    int          edge_hues [14] = '{0, 59, 60, 119, 120, 179, 180, 239, 240,
                                    299, 300, 359, 360, 1023};
    case ($urandom_range(0, 9))
      0, 1:    req.hue_req = {1'b1, (HUE_REQ_W-1)'($urandom)};
      2:       req.hue_req = HUE_REQ_W'(edge_hues[$urandom_range(0, 13)]);
      default: req.hue_req = HUE_REQ_W'($urandom_range(0, 1023));
    endcase
    req.rnd_hue = RAND_HUE_W'($urandom_range(0, 511));
    req.light   = random_fraction();
    req.sat     = random_fraction();
    req.alpha   = random_fraction();
    return req;
  endfunction

  // Receiver: stall pattern that is redrawn periodically, and a long
  // hold-off on request that lets the unit fill up.
  initial begin
    int rx_mode;
    int rx_count;
    bit held;
    rx_mode  = 0;
    rx_count = 0;
    held     = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held       = 1'b1;
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        rx_count++;
        if (rx_count % 50 == 0)
          rx_mode = $urandom_range(0, 3);
        case (rx_mode)
          0:       out_tready = 1'b1;
          1:       out_tready = 1'($urandom_range(0, 1));
          2:       out_tready = ($urandom_range(0, 3) == 0);
          default: out_tready = (rx_count % 8 != 5);
        endcase
      end
    end
  end

  // Result checking against the oldest expected colour.
  always @(posedge clk) begin
    rgba_t got;
    rgba_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (colour_queue.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_MAX)
          $display("Unexpected colour r=%0d g=%0d b=%0d a=%0d",
                   got.red, got.green, got.blue, got.alpha);
      end else begin
        want = colour_queue.pop_front();
        if (got.red !== want.red || got.green !== want.green ||
            got.blue !== want.blue || got.alpha !== want.alpha) begin
          fault_count++;
          if (fault_count <= REPORT_MAX)
            $display({"Colour differs: expected r=%0d g=%0d b=%0d a=%0d, ",
                      "got r=%0d g=%0d b=%0d a=%0d"},
                     want.red, want.green, want.blue, want.alpha,
                     got.red, got.green, got.blue, got.alpha);
        end
      end
    end
  end

  // Main sequence: reset, directed rows, then random phases per setting.
  initial begin
    colour_req_t req;
    rgba_t       typed;
    burst_left  = 0;
    hold_req    = 1'b0;
    rst_n       = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    bound_regs[REG_LIGHT_MIN] = '0;
    bound_regs[REG_LIGHT_MAX] = (FRAC_BITS+1)'(UNIT);
    bound_regs[REG_SAT_MIN]   = '0;
    bound_regs[REG_SAT_MAX]   = (FRAC_BITS+1)'(UNIT);
    bound_regs[REG_ALPHA_MIN] = (FRAC_BITS+1)'(UNIT);
    bound_regs[REG_ALPHA_MAX] = (FRAC_BITS+1)'(UNIT);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part under the register values after reset.
    foreach (dir_rows[i]) begin
      req.hue_req = HUE_REQ_W'(dir_rows[i].hreq);
      req.rnd_hue = RAND_HUE_W'(dir_rows[i].rhue);
      req.light   = FRAC_BITS'(dir_rows[i].rl);
      req.sat     = FRAC_BITS'(dir_rows[i].rs);
      req.alpha   = FRAC_BITS'(dir_rows[i].ra);
      typed       = '0;
      typed.red   = (FRAC_BITS+1)'(dir_rows[i].er);
      typed.green = (FRAC_BITS+1)'(dir_rows[i].eg);
      typed.blue  = (FRAC_BITS+1)'(dir_rows[i].eb);
      typed.alpha = (FRAC_BITS+1)'(dir_rows[i].ea);
      send_request(req, dir_rows[i].fixed, typed);
    end

    // Random phases, each under its own register setting.
    for (int p = 0; p < PHASES; p++) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      while (colour_queue.size() != 0) @(posedge clk);
      repeat (8) @(posedge clk);
      case (p)
        0: begin
          // Reversed bounds, and a bound above one read as one.
          cfg_write(REG_LIGHT_MIN, 32'd4096);
          cfg_write(REG_LIGHT_MAX, 32'd0);
          cfg_write(REG_SAT_MIN,   32'd8191);
          cfg_write(REG_SAT_MAX,   32'd0);
          cfg_write(REG_ALPHA_MIN, 32'd0);
          cfg_write(REG_ALPHA_MAX, 32'd4096);
        end
        1: begin
          // Black at full saturation, opacity falling from one to zero.
          cfg_write(REG_LIGHT_MIN, 32'd0);
          cfg_write(REG_LIGHT_MAX, 32'd0);
          cfg_write(REG_SAT_MIN,   32'd4096);
          cfg_write(REG_SAT_MAX,   32'd4096);
          cfg_write(REG_ALPHA_MIN, 32'd4096);
          cfg_write(REG_ALPHA_MAX, 32'd0);
        end
        2: begin
          // Any written word, upper bits ignored; the receiver holds off.
          cfg_write(REG_LIGHT_MIN, $urandom);
          cfg_write(REG_LIGHT_MAX, $urandom);
          cfg_write(REG_SAT_MIN,   $urandom);
          cfg_write(REG_SAT_MAX,   $urandom);
          cfg_write(REG_ALPHA_MIN, $urandom);
          cfg_write(REG_ALPHA_MAX, $urandom);
          hold_req = 1'b1;
        end
        3: begin
          cfg_write(REG_LIGHT_MIN, $urandom_range(0, 4096));
          cfg_write(REG_LIGHT_MAX, $urandom_range(0, 4096));
          cfg_write(REG_SAT_MIN,   $urandom_range(0, 4096));
          cfg_write(REG_SAT_MAX,   $urandom_range(0, 4096));
          cfg_write(REG_ALPHA_MIN, $urandom_range(0, 4096));
          cfg_write(REG_ALPHA_MAX, $urandom_range(0, 4096));
        end
        default: begin
          // Back to the full ranges; writes past the last register are dropped.
          cfg_write(REG_LIGHT_MIN, 32'd0);
          cfg_write(REG_LIGHT_MAX, 32'd4096);
          cfg_write(REG_SAT_MIN,   32'd0);
          cfg_write(REG_SAT_MAX,   32'd4096);
          cfg_write(REG_ALPHA_MIN, 32'd0);
          cfg_write(REG_ALPHA_MAX, 32'd4096);
          cfg_write(NUM_REGS,      $urandom);
          cfg_write(NUM_REGS + 1,  $urandom);
        end
      endcase
      typed = '0;
      repeat (PHASE_ITEMS) send_request(random_request(), 1'b0, typed);
    end

    // Drain and let any stray result show up.
    @(negedge clk);
    in_tvalid = 1'b0;
    while (colour_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fault_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
